FILE: rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, constants and helpers for the particle boundary block.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam int unsigned XW            = 32;  // position / velocity width
  localparam int unsigned DIM_W         = 31;  // domain extent width
  localparam int unsigned CFG_AW        = 2;
  localparam int unsigned CFG_DW        = 32;
  localparam int unsigned VIN_W         = 33;  // normalizer operand width
  localparam int unsigned WORK_W        = 36;  // wall arithmetic width

  typedef enum logic [CFG_AW-1:0] {
    REG_DOMAIN_WIDTH,
    REG_DOMAIN_HEIGHT,
    REG_BORDER_SPEED,
    REG_BOUNDARY_MODE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_PERIODIC,
    MODE_TOP_WALL,
    MODE_TWO_WALLS
  } boundary_mode_e;

  typedef struct packed {
    logic signed [XW-1:0] pos_x;
    logic signed [XW-1:0] pos_y;
    logic signed [XW-1:0] vel_x;
    logic signed [XW-1:0] vel_y;
  } pbc_in_t;

  typedef struct packed {
    logic signed [XW-1:0] new_pos_x;
    logic signed [XW-1:0] new_pos_y;
    logic signed [XW-1:0] new_vel_x;
    logic signed [XW-1:0] new_vel_y;
  } pbc_out_t;

  // particle state carried alongside a normalization
  typedef struct packed {
    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic                 hit;
  } pbc_ctx_t;

  function automatic logic signed [XW-1:0] sat32(input logic signed [WORK_W-1:0] v);
    logic signed [WORK_W-1:0] hi;
    logic signed [WORK_W-1:0] lo;
    hi = WORK_W'(64'sd2147483647);
    lo = WORK_W'(-64'sd2147483648);
    if (v > hi) begin
      return XW'(hi);
    end else if (v < lo) begin
      return XW'(lo);
    end
    return XW'(v);
  endfunction

endpackage

FILE: rtl/particle_boundary_condition.sv
// ----------------------------------------------------------------------------
// particle_boundary_condition
// Applies the 2D domain boundary rule to one particle request per cycle.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle enters and one result per cycle
// leaves while the output is not stalled (Q16.16 by default). The depth
// is mostly the two normalizers in series (top wall, then bottom wall),
// each with one stage per bit of the 32-bit square root and one per
// quotient bit of the FRAC_BITS+1 bit divide. When the output is stalled the
// whole pipeline holds and a one-entry skid buffer takes one more request.
// Configuration may only be written while no request is in flight.
module particle_boundary_condition #(
  parameter int unsigned FRAC_BITS = pbc_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pbc_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [pbc_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pbc_pkg::pbc_in_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pbc_pkg::pbc_out_t           out_rsp_o
);
  import pbc_pkg::*;

  localparam int unsigned WW = WORK_W;
  localparam logic signed [WW-1:0] One = WW'(64'sd1 <<< FRAC_BITS);

  // configuration
  logic [DIM_W-1:0]     width_q, height_q;
  logic signed [XW-1:0] speed_q;
  logic [1:0]           mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(33554432);
      height_q <= DIM_W'(33554432);
      speed_q  <= '0;
      mode_q   <= MODE_PERIODIC;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DOMAIN_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_DOMAIN_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_BORDER_SPEED:  speed_q  <= signed'(cfg_data_i);
        REG_BOUNDARY_MODE: mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [WW-1:0] cfg_w, cfg_h, cfg_b;
  logic                 top_mode, two_mode, walls;

  assign cfg_w    = WW'(signed'({1'b0, width_q}));
  assign cfg_h    = WW'(signed'({1'b0, height_q}));
  assign cfg_b    = WW'(speed_q);
  assign top_mode = mode_q == MODE_TOP_WALL;
  assign two_mode = mode_q == MODE_TWO_WALLS;
  assign walls    = top_mode || two_mode;

  // pipeline advance and input skid
  logic    en;
  logic    out_vld_q;
  logic    skid_full_q;
  pbc_in_t skid_q;
  logic    src_vld;
  pbc_in_t src;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = !skid_full_q;
  assign src_vld    = skid_full_q || in_valid_i;
  assign src        = skid_full_q ? skid_q : in_req_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (en) begin
      skid_full_q <= 1'b0;
    end else if (in_valid_i && !skid_full_q) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_full_q) begin
      skid_q <= in_req_i;
    end
  end

  // stage 1: wrap first step (y only without walls), top test, wall speed
  logic    s1_vld_q;
  pbc_in_t s1_q;

  logic signed [WW-1:0] s1_px, s1_py, s1_px1, s1_py1, s1_vxt;
  logic                 s1_hit;

  always_comb begin
    s1_px  = WW'(s1_q.pos_x);
    s1_py  = WW'(s1_q.pos_y);
    s1_px1 = (s1_px >= cfg_w) ? s1_px - cfg_w : s1_px;
    s1_py1 = (!walls && s1_py >= cfg_h) ? s1_py - cfg_h : s1_py;
    s1_hit = walls && (s1_py >= cfg_h - One);
    s1_vxt = WW'(s1_q.vel_x) + cfg_b;
  end

  // stage 2: wrap second step
  logic                    s2_vld_q;
  logic signed [XW-1:0]    s2_px_q, s2_py_q, s2_vx_q, s2_vy_q;
  logic signed [VIN_W-1:0] s2_vxt_q;
  logic                    s2_hit_q;

  logic signed [WW-1:0] s2_px, s2_py;
  pbc_ctx_t             s2_ctx;

  always_comb begin
    s2_px = WW'(s2_px_q);
    s2_py = WW'(s2_py_q);
    if (s2_px <= 0) begin
      s2_px = s2_px + cfg_w;
    end
    if (!walls && s2_py <= 0) begin
      s2_py = s2_py + cfg_h;
    end
    s2_ctx.px  = XW'(s2_px);
    s2_ctx.py  = XW'(s2_py);
    s2_ctx.vx  = s2_vx_q;
    s2_ctx.vy  = s2_vy_q;
    s2_ctx.hit = s2_hit_q;
  end

  logic                 n1_vld;
  pbc_ctx_t             n1_ctx;
  logic signed [XW-1:0] n1_vx, n1_vy;

  pbc_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .ctx_i  (s2_ctx),
    .vx_i   (s2_vxt_q),
    .vy_i   (VIN_W'(s2_vy_q)),
    .vld_o  (n1_vld),
    .ctx_o  (n1_ctx),
    .vx_o   (n1_vx),
    .vy_o   (n1_vy)
  );

  // stage 3: top wall overshoot
  logic                 s3_vld_q;
  logic signed [XW-1:0] s3_px_q, s3_py_q, s3_vx_q, s3_vy_q;
  logic signed [WW-1:0] s3_d_q;
  logic                 s3_hit_q;

  // stage 4: after top reflection
  logic                 s4_vld_q;
  logic signed [XW-1:0] s4_px_q, s4_py_q, s4_vx_q, s4_vy_q;

  logic                 s3_refl;
  logic signed [XW-1:0] s3_py, s3_vy;

  always_comb begin
    s3_refl = s3_hit_q && (s3_d_q >= 0);
    s3_py   = s3_refl ? sat32(WW'(s3_py_q) - (s3_d_q <<< 1)) : s3_py_q;
    s3_vy   = s3_refl ? -s3_vy_q : s3_vy_q;
  end

  // stage 5: bottom mirror or bottom wall test
  logic                    s5_vld_q;
  logic signed [XW-1:0]    s5_px_q, s5_py_q, s5_vx_q, s5_vy_q;
  logic signed [VIN_W-1:0] s5_vxb_q;
  logic                    s5_bot_q;

  logic                 s4_mir, s4_bot;
  logic signed [XW-1:0] s4_py, s4_vy;
  logic signed [WW-1:0] s4_vxb;

  always_comb begin
    s4_mir = top_mode && (s4_py_q <= 0);
    s4_py  = s4_mir ? sat32(-WW'(s4_py_q)) : s4_py_q;
    s4_vy  = s4_mir ? sat32(-WW'(s4_vy_q)) : s4_vy_q;
    s4_bot = two_mode && (WW'(s4_py_q) <= One);
    s4_vxb = WW'(s4_vx_q) - cfg_b;
  end

  pbc_ctx_t s5_ctx;

  always_comb begin
    s5_ctx.px  = s5_px_q;
    s5_ctx.py  = s5_py_q;
    s5_ctx.vx  = s5_vx_q;
    s5_ctx.vy  = s5_vy_q;
    s5_ctx.hit = s5_bot_q;
  end

  logic                 n2_vld;
  pbc_ctx_t             n2_ctx;
  logic signed [XW-1:0] n2_vx, n2_vy;

  pbc_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_bot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .ctx_i  (s5_ctx),
    .vx_i   (s5_vxb_q),
    .vy_i   (VIN_W'(s5_vy_q)),
    .vld_o  (n2_vld),
    .ctx_o  (n2_ctx),
    .vx_o   (n2_vx),
    .vy_o   (n2_vy)
  );

  // stage 6: bottom wall overshoot
  logic                 s6_vld_q;
  logic signed [XW-1:0] s6_px_q, s6_py_q, s6_vx_q, s6_vy_q;
  logic signed [WW-1:0] s6_d_q;
  logic                 s6_hit_q;

  logic                 s6_refl;
  pbc_out_t             out_d, out_q;

  always_comb begin
    s6_refl         = s6_hit_q && (s6_d_q <= 0);
    out_d.new_pos_x = s6_px_q;
    out_d.new_pos_y = s6_refl ? sat32(WW'(s6_py_q) - (s6_d_q <<< 1)) : s6_py_q;
    out_d.new_vel_x = s6_vx_q;
    out_d.new_vel_y = s6_refl ? -s6_vy_q : s6_vy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= src_vld;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= n1_vld;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= n2_vld;
      out_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= src;

      s2_px_q  <= XW'(s1_px1);
      s2_py_q  <= XW'(s1_py1);
      s2_vx_q  <= s1_q.vel_x;
      s2_vy_q  <= s1_q.vel_y;
      s2_vxt_q <= VIN_W'(s1_vxt);
      s2_hit_q <= s1_hit;

      s3_px_q  <= n1_ctx.px;
      s3_py_q  <= n1_ctx.py;
      s3_vx_q  <= n1_ctx.hit ? n1_vx : n1_ctx.vx;
      s3_vy_q  <= n1_ctx.hit ? n1_vy : n1_ctx.vy;
      s3_d_q   <= WW'(n1_ctx.py) + WW'(n1_vy) - cfg_h;
      s3_hit_q <= n1_ctx.hit;

      s4_px_q  <= s3_px_q;
      s4_py_q  <= s3_py;
      s4_vx_q  <= s3_vx_q;
      s4_vy_q  <= s3_vy;

      s5_px_q  <= s4_px_q;
      s5_py_q  <= s4_py;
      s5_vx_q  <= s4_vx_q;
      s5_vy_q  <= s4_vy;
      s5_vxb_q <= VIN_W'(s4_vxb);
      s5_bot_q <= s4_bot;

      s6_px_q  <= n2_ctx.px;
      s6_py_q  <= n2_ctx.py;
      s6_vx_q  <= n2_ctx.hit ? n2_vx : n2_ctx.vx;
      s6_vy_q  <= n2_ctx.hit ? n2_vy : n2_ctx.vy;
      s6_d_q   <= WW'(n2_ctx.py) + WW'(n2_vy);
      s6_hit_q <= n2_ctx.hit;

      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_skid_only_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_o)
    else $error("skid buffer holds a request while the output is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && en) |=> !skid_full_q)
    else $error("skid buffer not drained on pipeline advance");

  a_no_phantom_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !src_vld) |=> !s1_vld_q)
    else $error("first stage became valid without a request");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_vld_q) && $stable(s6_vld_q)))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: rtl/pbc_norm.sv
// ----------------------------------------------------------------------------
// pbc_norm
// Pipelined unit-length normalizer: scale, square, digit-serial root and
// restoring division, one stage per root bit and per quotient bit.
// ----------------------------------------------------------------------------
module pbc_norm #(
  parameter int unsigned FRAC_BITS = pbc_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  pbc_pkg::pbc_ctx_t                 ctx_i,
  input  logic signed [pbc_pkg::VIN_W-1:0]  vx_i,
  input  logic signed [pbc_pkg::VIN_W-1:0]  vy_i,
  output logic                              vld_o,
  output pbc_pkg::pbc_ctx_t                 ctx_o,
  output logic signed [pbc_pkg::XW-1:0]     vx_o,
  output logic signed [pbc_pkg::XW-1:0]     vy_o
);
  import pbc_pkg::*;

  localparam int unsigned MAG_W  = VIN_W;
  localparam int unsigned NRM_W  = 31;
  localparam int unsigned SQ_W   = 2 * NRM_W;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned DREM_W = ROOT_W + 1;
  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned POS_W  = $clog2(MAG_W);
  localparam logic [POS_W-1:0] TGT = POS_W'(NRM_W - 1);

  typedef struct packed {
    pbc_ctx_t ctx;
    logic     sx;
    logic     sy;
    logic     zero;
  } side_t;

  // stage A: magnitudes
  logic             a_vld_q;
  side_t            a_side_q, a_side_d;
  logic [MAG_W-1:0] a_ax_q, a_ay_q, a_ax_d, a_ay_d;

  always_comb begin
    a_side_d.ctx  = ctx_i;
    a_side_d.sx   = vx_i[MAG_W-1];
    a_side_d.sy   = vy_i[MAG_W-1];
    a_side_d.zero = (vx_i == '0) && (vy_i == '0);
    a_ax_d = vx_i[MAG_W-1] ? MAG_W'(-vx_i) : MAG_W'(vx_i);
    a_ay_d = vy_i[MAG_W-1] ? MAG_W'(-vy_i) : MAG_W'(vy_i);
  end

  // stage B: larger magnitude
  logic             b_vld_q;
  side_t            b_side_q;
  logic [MAG_W-1:0] b_ax_q, b_ay_q, b_m_q, b_m_d;

  assign b_m_d = (a_ax_q > a_ay_q) ? a_ax_q : a_ay_q;

  // stage C: leading one
  logic             c_vld_q;
  side_t            c_side_q;
  logic [MAG_W-1:0] c_ax_q, c_ay_q;
  logic [POS_W-1:0] c_pos_q, c_pos_d;

  always_comb begin
    c_pos_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (b_m_q[i]) begin
        c_pos_d = POS_W'(i);
      end
    end
  end

  // stage D: scale both so the larger lies in [2^30, 2^31)
  logic             d_vld_q;
  side_t            d_side_q;
  logic [NRM_W-1:0] d_ax_q, d_ay_q, d_ax_d, d_ay_d;

  always_comb begin
    if (c_pos_q > TGT) begin
      d_ax_d = NRM_W'(c_ax_q >> (c_pos_q - TGT));
      d_ay_d = NRM_W'(c_ay_q >> (c_pos_q - TGT));
    end else begin
      d_ax_d = NRM_W'(c_ax_q << (TGT - c_pos_q));
      d_ay_d = NRM_W'(c_ay_q << (TGT - c_pos_q));
    end
  end

  // stage E: squares
  logic             e_vld_q;
  side_t            e_side_q;
  logic [NRM_W-1:0] e_ax_q, e_ay_q;
  logic [SQ_W-1:0]  e_sx_q, e_sy_q, e_sx_d, e_sy_d;

  assign e_sx_d = d_ax_q * d_ax_q;
  assign e_sy_d = d_ay_q * d_ay_q;

  // root pipeline, index 0 holds the radicand
  logic              sq_vld_q  [ROOT_W+1];
  side_t             sq_side_q [ROOT_W+1];
  logic [RAD_W-1:0]  sq_rad_q  [ROOT_W+1];
  logic [REM_W-1:0]  sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_q [ROOT_W+1];
  logic [NRM_W-1:0]  sq_ax_q   [ROOT_W+1];
  logic [NRM_W-1:0]  sq_ay_q   [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      a_vld_q     <= vld_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      d_vld_q     <= c_vld_q;
      e_vld_q     <= d_vld_q;
      sq_vld_q[0] <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q     <= a_side_d;
      a_ax_q       <= a_ax_d;
      a_ay_q       <= a_ay_d;
      b_side_q     <= a_side_q;
      b_ax_q       <= a_ax_q;
      b_ay_q       <= a_ay_q;
      b_m_q        <= b_m_d;
      c_side_q     <= b_side_q;
      c_ax_q       <= b_ax_q;
      c_ay_q       <= b_ay_q;
      c_pos_q      <= c_pos_d;
      d_side_q     <= c_side_q;
      d_ax_q       <= d_ax_d;
      d_ay_q       <= d_ay_d;
      e_side_q     <= d_side_q;
      e_ax_q       <= d_ax_q;
      e_ay_q       <= d_ay_q;
      e_sx_q       <= e_sx_d;
      e_sy_q       <= e_sy_d;
      sq_side_q[0] <= e_side_q;
      sq_rad_q[0]  <= RAD_W'(e_sx_q) + RAD_W'(e_sy_q);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_ax_q[0]   <= e_ax_q;
      sq_ay_q[0]   <= e_ay_q;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_x, trial, rem_n;
    logic [ROOT_W-1:0] root_n;
    logic              ge;

    always_comb begin
      rem_x  = {sq_rem_q[k][REM_W-3:0], sq_rad_q[k][RAD_W-1-2*k -: 2]};
      trial  = REM_W'({sq_root_q[k], 2'b01});
      ge     = rem_x >= trial;
      rem_n  = ge ? rem_x - trial : rem_x;
      root_n = {sq_root_q[k][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_side_q[k+1] <= sq_side_q[k];
        sq_rad_q[k+1]  <= sq_rad_q[k];
        sq_rem_q[k+1]  <= rem_n;
        sq_root_q[k+1] <= root_n;
        sq_ax_q[k+1]   <= sq_ax_q[k];
        sq_ay_q[k+1]   <= sq_ay_q[k];
      end
    end
  end

  // division pipeline, one quotient bit per stage
  logic              dv_vld_q  [1:QW];
  side_t             dv_side_q [1:QW];
  logic [ROOT_W-1:0] dv_n_q    [1:QW];
  logic [DREM_W-1:0] dv_rx_q   [1:QW];
  logic [DREM_W-1:0] dv_ry_q   [1:QW];
  logic [QW-1:0]     dv_qx_q   [1:QW];
  logic [QW-1:0]     dv_qy_q   [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic              p_vld;
    side_t             p_side;
    logic [ROOT_W-1:0] p_n;
    logic [DREM_W-1:0] p_rx, p_ry, sub_x, sub_y;
    logic [QW-1:0]     p_qx, p_qy;
    logic              ge_x, ge_y;

    if (j == 0) begin : g_first
      assign p_vld  = sq_vld_q[ROOT_W];
      assign p_side = sq_side_q[ROOT_W];
      assign p_n    = sq_root_q[ROOT_W];
      assign p_rx   = DREM_W'(sq_ax_q[ROOT_W]);
      assign p_ry   = DREM_W'(sq_ay_q[ROOT_W]);
      assign p_qx   = '0;
      assign p_qy   = '0;
    end else begin : g_next
      assign p_vld  = dv_vld_q[j];
      assign p_side = dv_side_q[j];
      assign p_n    = dv_n_q[j];
      assign p_rx   = dv_rx_q[j];
      assign p_ry   = dv_ry_q[j];
      assign p_qx   = dv_qx_q[j];
      assign p_qy   = dv_qy_q[j];
    end

    always_comb begin
      ge_x  = p_rx >= DREM_W'(p_n);
      ge_y  = p_ry >= DREM_W'(p_n);
      sub_x = ge_x ? p_rx - DREM_W'(p_n) : p_rx;
      sub_y = ge_y ? p_ry - DREM_W'(p_n) : p_ry;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[j+1] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_side_q[j+1] <= p_side;
        dv_n_q[j+1]    <= p_n;
        dv_rx_q[j+1]   <= {sub_x[DREM_W-2:0], 1'b0};
        dv_ry_q[j+1]   <= {sub_y[DREM_W-2:0], 1'b0};
        dv_qx_q[j+1]   <= {p_qx[QW-2:0], ge_x};
        dv_qy_q[j+1]   <= {p_qy[QW-2:0], ge_y};
      end
    end
  end

  // sign restore
  logic                 out_vld_q;
  pbc_ctx_t             out_ctx_q;
  logic signed [XW-1:0] out_vx_q, out_vy_q, out_vx_d, out_vy_d;

  always_comb begin
    out_vx_d = dv_side_q[QW].sx ? -signed'(XW'(dv_qx_q[QW])) : signed'(XW'(dv_qx_q[QW]));
    out_vy_d = dv_side_q[QW].sy ? -signed'(XW'(dv_qy_q[QW])) : signed'(XW'(dv_qy_q[QW]));
    if (dv_side_q[QW].zero) begin
      out_vx_d = '0;
      out_vy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_ctx_q <= dv_side_q[QW].ctx;
      out_vx_q  <= out_vx_d;
      out_vy_q  <= out_vy_d;
    end
  end

  assign vld_o = out_vld_q;
  assign ctx_o = out_ctx_q;
  assign vx_o  = out_vx_q;
  assign vy_o  = out_vy_q;

endmodule
